[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define BPFM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bpfm assertion failed");
// expression must never be true outside reset
`define BPFM_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("bpfm forbidden condition");
`else
`define BPFM_ASSERT(lbl, clk, rst_n, prop)
`define BPFM_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[rtl/bpfm_pkg.sv]
// types, constants and codes of the buffer pool frame manager
`timescale 1ns / 1ps
package bpfm_pkg;
    localparam int FRAMES  = 1024;
    localparam int FRAME_W = $clog2(FRAMES);
    localparam int CNT_W   = $clog2(FRAMES);
    localparam int PIN_W   = 16;

    localparam logic [1:0] OP_GET     = 2'd0;
    localparam logic [1:0] OP_APPEND  = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_NO_FRAME = 3'd2;
    localparam logic [2:0] ST_BAD_PAGE = 3'd3;
    localparam logic [2:0] ST_RELEASED = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  file_id;
        logic [31:0] req_page;
        logic [31:0] file_page_count;
        logic [9:0]  release_frame;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  frame;
        logic        read_request;
        logic        evicted_valid;
        logic [7:0]  evicted_file;
        logic [31:0] evicted_page;
    } res_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_REL_RD, S_REL_WR,
        S_LOOK_RD, S_LOOK_CMP, S_SWEEP_RD, S_SWEEP_CMP
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD, IDX_ZERO, IDX_INC, IDX_REL, IDX_SWEEP
    } idx_op_t;

    typedef enum logic [1:0] {
        META_CLEAR, META_INC, META_DEC, META_NEW
    } meta_op_t;

    typedef enum logic [2:0] {
        EMIT_HIT, EMIT_MISS, EMIT_NO_FRAME, EMIT_BAD_PAGE, EMIT_RELEASED
    } emit_t;

    typedef struct packed {
        logic     load;
        idx_op_t  idx_op;
        logic     meta_wr;
        meta_op_t meta_op;
        logic     tag_wr;
        logic     ptr_wr;
        logic     emit;
        emit_t    emit_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       bad_page;
        logic       rel_ok;
        logic       match;
        logic       free;
        logic       last;
    } stat_t;
endpackage

[rtl/buffer_pool_page_frame_manager_core.sv]
// top level of the buffer pool frame manager
`timescale 1ns / 1ps
// channel   ports                 handshake
// request   start, busy, req      word taken when start high and busy low
// result    done, result          word valid for one cycle with done high
//
// after reset a clearing pass over all FRAMES (1024) runs with busy high
// get and append: decode, then a lookup scan frame by frame until a match,
//   then a victim sweep from the rotating pointer until a frame is free
// release: read, write back; bad page: at decode; unused opcode: no result
// the frame memories have a registered read port; results cannot be stalled
module buffer_pool_page_frame_manager_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  bpfm_pkg::req_t  req,
    output logic            done,
    output bpfm_pkg::res_t  result
);
    import bpfm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencing
    bpfm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // storage and result
    bpfm_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );
endmodule

[rtl/bpfm_dp.sv]
// datapath: request registers, frame tag and pin memories, result register
`timescale 1ns / 1ps
module bpfm_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  bpfm_pkg::req_t  req,
    input  bpfm_pkg::cmd_t  cmd,
    output bpfm_pkg::stat_t stat,
    output logic          done,
    output bpfm_pkg::res_t  result
);
    import bpfm_pkg::*;

    typedef struct packed {
        logic             valid;
        logic [PIN_W-1:0] pin;
    } meta_t;

    typedef struct packed {
        logic [7:0]  file;
        logic [31:0] page;
    } tag_t;

    meta_t meta_mem [FRAMES];
    tag_t  tag_mem  [FRAMES];
    meta_t meta_q;
    tag_t  tag_q;
    meta_t meta_wdata;

    logic [1:0]         op_reg;
    logic [7:0]         fid_reg;
    logic [31:0]        key_reg;
    logic               bad_reg;
    logic [9:0]         rel_reg;
    logic [FRAME_W-1:0] idx_reg, idx_next, idx_inc;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [FRAME_W-1:0] ptr_reg;
    logic               done_reg;
    res_t               res_reg, res_next;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.opcode;
            fid_reg <= req.file_id;
            rel_reg <= req.release_frame;
            key_reg <= (req.opcode == OP_APPEND) ? req.file_page_count : req.req_page;
            bad_reg <= (req.opcode == OP_GET) && (req.req_page != 32'd0)
                       && (req.file_page_count < req.req_page);
        end
    end

    // frame index with wrap
    assign idx_inc = (idx_reg == FRAME_W'(FRAMES - 1)) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        unique case (cmd.idx_op)
            IDX_HOLD:  ;
            IDX_ZERO:  begin idx_next = '0; cnt_next = '0; end
            IDX_INC:   begin idx_next = idx_inc; cnt_next = cnt_reg + 1'b1; end
            IDX_REL:   begin idx_next = FRAME_W'(rel_reg); cnt_next = '0; end
            IDX_SWEEP: begin idx_next = ptr_reg; cnt_next = '0; end
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            if (cmd.ptr_wr)
                ptr_reg <= idx_inc;
        end
    end

    // pin and valid word to write back
    always_comb
    begin
        unique case (cmd.meta_op)
            META_CLEAR: meta_wdata = '0;
            META_INC:   meta_wdata = '{valid: meta_q.valid,
                            pin: (&meta_q.pin) ? meta_q.pin : meta_q.pin + 1'b1};
            META_DEC:   meta_wdata = '{valid: meta_q.valid,
                            pin: (meta_q.pin == '0) ? meta_q.pin : meta_q.pin - 1'b1};
            META_NEW:   meta_wdata = '{valid: 1'b1, pin: PIN_W'(1)};
            default:    meta_wdata = '0;
        endcase
    end

    // memories, registered read at the current index
    always_ff @(posedge clk)
    begin
        if (cmd.meta_wr)
            meta_mem[idx_reg] <= meta_wdata;
        if (cmd.tag_wr)
            tag_mem[idx_reg] <= '{file: fid_reg, page: key_reg};
        meta_q <= meta_mem[idx_reg];
        tag_q  <= tag_mem[idx_reg];
    end

    // status to the controller
    assign stat = '{opcode: op_reg, bad_page: bad_reg,
                    rel_ok: (32'(rel_reg) < 32'(FRAMES)),
                    match: meta_q.valid && (tag_q.file == fid_reg) && (tag_q.page == key_reg),
                    free: (meta_q.pin == '0),
                    last: (cnt_reg == CNT_W'(FRAMES - 1))};

    // result word
    always_comb
    begin
        res_next = '0;
        unique case (cmd.emit_sel)
            EMIT_HIT:
            begin
                res_next.status = ST_HIT;
                res_next.frame  = 10'(idx_reg);
            end
            EMIT_MISS:
            begin
                res_next.status        = ST_MISS;
                res_next.frame         = 10'(idx_reg);
                res_next.read_request  = 1'b1;
                res_next.evicted_valid = meta_q.valid;
                res_next.evicted_file  = meta_q.valid ? tag_q.file : 8'd0;
                res_next.evicted_page  = meta_q.valid ? tag_q.page : 32'd0;
            end
            EMIT_NO_FRAME: res_next.status = ST_NO_FRAME;
            EMIT_BAD_PAGE: res_next.status = ST_BAD_PAGE;
            EMIT_RELEASED:
            begin
                res_next.status = ST_RELEASED;
                res_next.frame  = rel_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

[rtl/bpfm_ctrl.sv]
// controller: clearing pass, lookup scan, victim sweep and release sequencing
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpfm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  bpfm_pkg::stat_t stat,
    output bpfm_pkg::cmd_t  cmd,
    output logic            busy
);
    import bpfm_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '{load: 1'b0, idx_op: IDX_HOLD, meta_wr: 1'b0, meta_op: META_CLEAR,
                tag_wr: 1'b0, ptr_wr: 1'b0, emit: 1'b0, emit_sel: EMIT_HIT};
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.meta_wr = 1'b1;
                cmd.idx_op  = stat.last ? IDX_ZERO : IDX_INC;
                if (stat.last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (stat.opcode == OP_RELEASE)
                begin
                    if (stat.rel_ok)
                    begin
                        cmd.idx_op = IDX_REL;
                        state_next = S_REL_RD;
                    end
                    else
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EMIT_RELEASED;
                        state_next   = S_IDLE;
                    end
                end
                else if (stat.opcode == OP_GET || stat.opcode == OP_APPEND)
                begin
                    if (stat.bad_page)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EMIT_BAD_PAGE;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_ZERO;
                        state_next = S_LOOK_RD;
                    end
                end
                else
                    state_next = S_IDLE;
            end
            S_REL_RD:
                state_next = S_REL_WR;
            S_REL_WR:
            begin
                cmd.meta_wr  = 1'b1;
                cmd.meta_op  = META_DEC;
                cmd.emit     = 1'b1;
                cmd.emit_sel = EMIT_RELEASED;
                state_next   = S_IDLE;
            end
            S_LOOK_RD:
                state_next = S_LOOK_CMP;
            S_LOOK_CMP:
            begin
                priority if (stat.match)
                begin
                    cmd.meta_wr  = 1'b1;
                    cmd.meta_op  = META_INC;
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_HIT;
                    state_next   = S_IDLE;
                end
                else if (stat.last)
                begin
                    cmd.idx_op = IDX_SWEEP;
                    state_next = S_SWEEP_RD;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_LOOK_RD;
                end
            end
            S_SWEEP_RD:
                state_next = S_SWEEP_CMP;
            S_SWEEP_CMP:
            begin
                priority if (stat.free)
                begin
                    cmd.meta_wr  = 1'b1;
                    cmd.meta_op  = META_NEW;
                    cmd.tag_wr   = 1'b1;
                    cmd.ptr_wr   = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_MISS;
                    state_next   = S_IDLE;
                end
                else if (stat.last)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_NO_FRAME;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_SWEEP_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // a result always finishes the request
    `BPFM_ASSERT(a_emit_to_idle, clk, rst_n, cmd.emit |=> (state_reg == S_IDLE))
    // an accepted word is decoded next
    `BPFM_ASSERT(a_start_decode, clk, rst_n, (start && !busy) |=> (state_reg == S_DECODE))
    // tags are written only together with a fresh pin word
    `BPFM_NEVER(a_tag_meta, clk, rst_n, cmd.tag_wr && !(cmd.meta_wr && cmd.meta_op == META_NEW))
    // no memory write while waiting for a word
    `BPFM_NEVER(a_idle_quiet, clk, rst_n, (state_reg == S_IDLE) && (cmd.meta_wr || cmd.tag_wr))
endmodule

[tb/testbench.sv]
// self-checking testbench for the buffer pool frame manager core
`timescale 1ns / 1ps
module testbench;
    import bpfm_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_WORDS   = 770;
    localparam int CALM_WORDS     = 150;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    res_t result;

    buffer_pool_page_frame_manager_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    // own copy of the pool state
    bit          tag_valid [FRAMES];
    bit [7:0]    tag_file  [FRAMES];
    bit [31:0]   tag_page  [FRAMES];
    bit [15:0]   pin_cnt   [FRAMES];
    int unsigned victim_ptr;

    res_t pending_results [$];
    int   recent_frames [$];
    int   fail_count;
    int   quiet_cycles;
    bit   idle_on;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // work out the result of one accepted word and update the pool copy
    task automatic model_request(input req_t r);
        res_t        o;
        bit [31:0]   pg;
        int unsigned pos;
        bit          found;
        o     = '0;
        found = 1'b0;
        if (r.opcode == OP_RELEASE)
        begin
            if (pin_cnt[r.release_frame] != 0)
                pin_cnt[r.release_frame]--;
            o.status = ST_RELEASED;
            o.frame  = r.release_frame;
            pending_results.push_back(o);
        end
        else if (r.opcode == OP_GET || r.opcode == OP_APPEND)
        begin
            pg = (r.opcode == OP_APPEND) ? r.file_page_count : r.req_page;
            if (pg != 0 && r.file_page_count < pg)
                o.status = ST_BAD_PAGE;
            else
            begin
                // lookup among assigned frames
                for (int i = 0; i < FRAMES && !found; i++)
                begin
                    if (tag_valid[i] && tag_file[i] == r.file_id && tag_page[i] == pg)
                    begin
                        found = 1'b1;
                        if (pin_cnt[i] != 16'hFFFF)
                            pin_cnt[i]++;
                        o.status = ST_HIT;
                        o.frame  = 10'(i);
                    end
                end
                // victim sweep from the rotating pointer
                pos = victim_ptr;
                for (int i = 0; i < FRAMES && !found; i++)
                begin
                    if (pin_cnt[pos] == 0)
                    begin
                        found           = 1'b1;
                        o.status        = ST_MISS;
                        o.frame         = 10'(pos);
                        o.read_request  = 1'b1;
                        o.evicted_valid = tag_valid[pos];
                        if (tag_valid[pos])
                        begin
                            o.evicted_file = tag_file[pos];
                            o.evicted_page = tag_page[pos];
                        end
                        tag_valid[pos] = 1'b1;
                        tag_file[pos]  = r.file_id;
                        tag_page[pos]  = pg;
                        pin_cnt[pos]   = 16'd1;
                        victim_ptr     = (pos + 1) % FRAMES;
                        recent_frames.push_back(int'(pos));
                        if (recent_frames.size() > 32)
                            void'(recent_frames.pop_front());
                    end
                    pos = (pos + 1) % FRAMES;
                end
                if (!found)
                    o.status = ST_NO_FRAME;
            end
            pending_results.push_back(o);
        end
    endtask

    // send one word, with an optional idle burst first; start stays high after
    task automatic issue_request(input req_t r);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        model_request(r);
    endtask

    function automatic req_t make_req(input logic [1:0] op, input logic [7:0] fid,
                                      input logic [31:0] pg, input logic [31:0] cnt,
                                      input logic [9:0] rel);
        req_t r;
        r.opcode          = op;
        r.file_id         = fid;
        r.req_page        = pg;
        r.file_page_count = cnt;
        r.release_frame   = rel;
        return r;
    endfunction

    // lower start and wait for every expected word
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: status %0d frame %0d",
                       result.status, result.frame);
                fail_count++;
            end
            else
            begin
                res_t e;
                e = pending_results.pop_front();
                if (result.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, result.status);
                    fail_count++;
                end
                if (result.frame !== e.frame)
                begin
                    $error("frame: expected %0d, got %0d", e.frame, result.frame);
                    fail_count++;
                end
                if (result.read_request !== e.read_request)
                begin
                    $error("read_request: expected %0d, got %0d",
                           e.read_request, result.read_request);
                    fail_count++;
                end
                if (result.evicted_valid !== e.evicted_valid)
                begin
                    $error("evicted_valid: expected %0d, got %0d",
                           e.evicted_valid, result.evicted_valid);
                    fail_count++;
                end
                if (result.evicted_file !== e.evicted_file)
                begin
                    $error("evicted_file: expected %0d, got %0d",
                           e.evicted_file, result.evicted_file);
                    fail_count++;
                end
                if (result.evicted_page !== e.evicted_page)
                begin
                    $error("evicted_page: expected %0h, got %0h",
                           e.evicted_page, result.evicted_page);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // repeated hits on frame 0, then releases down past zero
    task automatic test_pin_count();
        for (int i = 0; i < 6; i++)
            issue_request(make_req(OP_GET, 8'd7, 32'd3, 32'd9, 10'd0));
        for (int i = 0; i < 8; i++)
            issue_request(make_req(OP_RELEASE, 8'd0, 32'd0, 32'd0, 10'd0));
        drain();
    endtask

    // field extremes, every operation, bad page, release at zero, unused opcode
    task automatic test_directed();
        issue_request(make_req(OP_GET, 8'd0, 32'd0, 32'd0, 10'd0));
        issue_request(make_req(OP_GET, 8'd0, 32'd0, 32'd0, 10'd0));
        issue_request(make_req(OP_GET, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0));
        issue_request(make_req(OP_GET, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 10'd0));
        issue_request(make_req(OP_GET, 8'd1, 32'd5, 32'd4, 10'd0));
        issue_request(make_req(OP_GET, 8'd1, 32'd4, 32'd4, 10'd0));
        issue_request(make_req(OP_APPEND, 8'd1, 32'd0, 32'd4, 10'd0));
        issue_request(make_req(OP_APPEND, 8'hFF, 32'd0, 32'hFFFF_FFFF, 10'h3FF));
        issue_request(make_req(OP_APPEND, 8'd2, 32'hFFFF_FFFF, 32'd0, 10'h3FF));
        issue_request(make_req(OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF));
        issue_request(make_req(OP_RELEASE, 8'd0, 32'd0, 32'd0, 10'd1));
        issue_request(make_req(OP_RELEASE, 8'd0, 32'd0, 32'd0, 10'd1));
        issue_request(make_req(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF));
        issue_request(make_req(OP_GET, 8'd1, 32'd4, 32'd4, 10'd0));
        issue_request(make_req(OP_UNUSED, 8'd0, 32'd0, 32'd0, 10'd0));
        issue_request(make_req(OP_RELEASE, 8'd0, 32'd0, 32'd0, 10'd0));
        drain();
    endtask

    // mostly well-formed traffic on a small key set, with some wide noise
    task automatic test_random();
        req_t r;
        int   pick;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS - CALM_WORDS)
                idle_on = 1'b0;
            r = make_req(2'($urandom_range(0, 2)), 8'($urandom_range(0, 3)),
                         32'($urandom_range(0, 7)), 32'($urandom_range(0, 9)),
                         10'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 5)
                r.opcode = OP_UNUSED;
            else if (pick < 45)
                r.opcode = OP_GET;
            else if (pick < 60)
                r.opcode = OP_APPEND;
            else
            begin
                r.opcode = OP_RELEASE;
                if (recent_frames.size() != 0 && $urandom_range(0, 4) != 0)
                    r.release_frame = 10'(recent_frames[$urandom_range(0,
                                                        recent_frames.size() - 1)]);
            end
            // occasional full-width noise in the file id, page and page count fields
            if ($urandom_range(0, 9) == 0)
            begin
                r.file_id         = 8'($urandom);
                r.req_page        = $urandom;
                r.file_page_count = $urandom;
            end
            issue_request(r);
        end
        drain();
    endtask

    // main sequence
    initial
    begin
        start        = 1'b0;
        req          = '0;
        rst_n        = 1'b0;
        fail_count   = 0;
        quiet_cycles = 0;
        idle_on      = 1'b1;
        victim_ptr   = 0;
        for (int i = 0; i < FRAMES; i++)
        begin
            tag_valid[i] = 1'b0;
            tag_file[i]  = '0;
            tag_page[i]  = '0;
            pin_cnt[i]   = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_pin_count();
        test_directed();
        test_random();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/bpfm_pkg.sv
rtl/bpfm_dp.sv
rtl/bpfm_ctrl.sv
rtl/buffer_pool_page_frame_manager_core.sv
tb/testbench.sv
